// ===== rtl/core/ioxrf_pkg.sv =====
`default_nettype none

package ioxrf_pkg;

  localparam int unsigned REG_COUNT_DEF = 80;

  localparam logic [1:0] CMD_SET_PTR = 2'd0;
  localparam logic [1:0] CMD_WRITE   = 2'd1;
  localparam logic [1:0] CMD_READ    = 2'd2;

  localparam logic [7:0] ADDR_IN0    = 8'h00;
  localparam logic [7:0] ADDR_IN1    = 8'h01;
  localparam logic [7:0] ADDR_LATCH0 = 8'h44;
  localparam logic [7:0] ADDR_LATCH1 = 8'h45;
  localparam logic [7:0] ADDR_MASK0  = 8'h4A;
  localparam logic [7:0] ADDR_MASK1  = 8'h4B;
  localparam logic [7:0] ADDR_STAT0  = 8'h4C;
  localparam logic [7:0] ADDR_STAT1  = 8'h4D;

  localparam logic [7:0] PAIR_LO_END = 8'h07;
  localparam logic [7:0] PAIR_HI_BEG = 8'h40;
  localparam logic [7:0] PAIR_HI_END = 8'h4D;

  localparam logic [7:0] BYTE_ONES = 8'hFF;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] data;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       read_valid;
    logic       int_n;
  } out_item_t;

  typedef struct packed {
    logic capture;
    logic exec;
  } ctl_t;

  function automatic logic [7:0] reg_default(logic [7:0] a);
    logic ones;
    begin
      ones = (a == 8'h02) || (a == 8'h03) || (a == 8'h06) || (a == 8'h07) ||
             ((a >= 8'h40) && (a <= 8'h43)) || ((a >= 8'h48) && (a <= 8'h4B));
      reg_default = ones ? BYTE_ONES : 8'h00;
    end
  endfunction

  function automatic logic [7:0] advance(logic [7:0] a);
    begin
      if ((a <= PAIR_LO_END) || ((a >= PAIR_HI_BEG) && (a <= PAIR_HI_END))) begin
        advance = a ^ 8'h01;
      end else begin
        advance = a + 8'h01;
      end
    end
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/ioxrf_regmem.sv =====
`default_nettype none

module ioxrf_regmem #(
  parameter int unsigned REG_COUNT = ioxrf_pkg::REG_COUNT_DEF,
  localparam int unsigned AW = $clog2(REG_COUNT)
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [7:0]    rd_data,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [7:0]    wr_data
);
  import ioxrf_pkg::*;

  logic [7:0]           mem [REG_COUNT];
  logic [REG_COUNT-1:0] vld_r;
  logic [7:0]           rd_data_r;

  // unwritten entries read as their reset default
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= vld_r[rd_addr] ? mem[rd_addr] : reg_default(8'(rd_addr));
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ===== rtl/core/ioxrf_ctrl.sv =====
`default_nettype none

module ioxrf_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  output ioxrf_pkg::ctl_t    ctl
);
  import ioxrf_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state_r;
  logic   out_valid_r;

  assign in_ready    = (state_r == S_IDLE);
  assign ctl.capture = in_valid && in_ready;
  assign ctl.exec    = (state_r == S_EXEC) && (!out_valid_r || out_ready);
  assign out_valid   = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (out_ready) begin
            out_valid_r <= 1'b0;
          end
          if (ctl.capture) begin
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (ctl.exec) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // result slot must be free when a transaction completes
  a_exec_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.exec |-> (!out_valid_r || out_ready))
    else $error("execute with result slot occupied");

  a_exec_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.exec |=> out_valid_r)
    else $error("result not presented after execute");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.capture |=> (!in_ready && !ctl.capture))
    else $error("second transaction accepted while one in flight");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctl.capture && ctl.exec))
    else $error("capture and execute in the same cycle");

endmodule

`default_nettype wire

// ===== rtl/core/ioxrf_dpath.sv =====
`default_nettype none

module ioxrf_dpath #(
  parameter int unsigned REG_COUNT = ioxrf_pkg::REG_COUNT_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire ioxrf_pkg::ctl_t      ctl,
  input  wire ioxrf_pkg::in_item_t  in_item,
  output ioxrf_pkg::out_item_t      out_item
);
  import ioxrf_pkg::*;

  localparam int unsigned AW = $clog2(REG_COUNT);

  in_item_t   item_r;
  out_item_t  out_item_r, out_item_nxt;

  logic [7:0] ptr_r, ptr_nxt;
  logic [7:0] in0_r, in0_nxt, in1_r, in1_nxt;
  logic [7:0] latch0_r, latch0_nxt, latch1_r, latch1_nxt;
  logic [7:0] mask0_r, mask0_nxt, mask1_r, mask1_nxt;
  logic [7:0] stat0_r, stat0_nxt, stat1_r, stat1_nxt;
  logic [7:0] prev0_r, prev0_nxt, prev1_r, prev1_nxt;
  logic [7:0] lat0_r, lat0_nxt, lat1_r, lat1_nxt;

  logic       in_range;
  logic       ded_hit;
  logic [7:0] ded_val;
  logic       mem_wr;
  logic       do_irq;
  logic [7:0] c0, c1;
  logic [7:0] rdata;
  logic       rvalid;
  logic [7:0] mem_rd_data;

  ioxrf_regmem #(
    .REG_COUNT (REG_COUNT)
  ) u_regmem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (ctl.capture),
    .rd_addr (ptr_r[AW-1:0]),
    .rd_data (mem_rd_data),
    .wr_en   (ctl.exec && mem_wr),
    .wr_addr (ptr_r[AW-1:0]),
    .wr_data (item_r.data)
  );

  assign in_range = {1'b0, ptr_r} < 9'(REG_COUNT);

  // fixed-address registers live in flops
  always_comb begin
    ded_hit = 1'b1;
    unique case (ptr_r)
      ADDR_IN0:    ded_val = in0_r;
      ADDR_IN1:    ded_val = in1_r;
      ADDR_LATCH0: ded_val = latch0_r;
      ADDR_LATCH1: ded_val = latch1_r;
      ADDR_MASK0:  ded_val = mask0_r;
      ADDR_MASK1:  ded_val = mask1_r;
      ADDR_STAT0:  ded_val = stat0_r;
      ADDR_STAT1:  ded_val = stat1_r;
      default: begin
        ded_hit = 1'b0;
        ded_val = 8'h00;
      end
    endcase
  end

  always_comb begin
    ptr_nxt    = ptr_r;
    in0_nxt    = in0_r;
    in1_nxt    = in1_r;
    latch0_nxt = latch0_r;
    latch1_nxt = latch1_r;
    mask0_nxt  = mask0_r;
    mask1_nxt  = mask1_r;
    stat0_nxt  = stat0_r;
    stat1_nxt  = stat1_r;
    prev0_nxt  = prev0_r;
    prev1_nxt  = prev1_r;
    lat0_nxt   = lat0_r;
    lat1_nxt   = lat1_r;
    mem_wr     = 1'b0;
    do_irq     = 1'b0;
    rdata      = 8'h00;
    rvalid     = 1'b0;
    c0         = 8'h00;
    c1         = 8'h00;

    unique case (item_r.cmd)
      CMD_SET_PTR: begin
        ptr_nxt = item_r.data;
        do_irq  = item_r.last;
      end
      CMD_WRITE: begin
        if (in_range) begin
          unique case (ptr_r)
            ADDR_IN0:    in0_nxt    = item_r.data;
            ADDR_IN1:    in1_nxt    = item_r.data;
            ADDR_LATCH0: latch0_nxt = item_r.data;
            ADDR_LATCH1: latch1_nxt = item_r.data;
            ADDR_MASK0:  mask0_nxt  = item_r.data;
            ADDR_MASK1:  mask1_nxt  = item_r.data;
            ADDR_STAT0:  stat0_nxt  = item_r.data;
            ADDR_STAT1:  stat1_nxt  = item_r.data;
            default:     mem_wr     = 1'b1;
          endcase
          ptr_nxt = advance(ptr_r);
        end
        do_irq = item_r.last;
      end
      CMD_READ: begin
        if (in_range) begin
          rdata  = ded_hit ? ded_val : mem_rd_data;
          rvalid = 1'b1;
          if ((ptr_r == ADDR_IN0) || (ptr_r == ADDR_IN1)) begin
            prev0_nxt = in0_r;
            prev1_nxt = in1_r;
            lat0_nxt  = 8'h00;
            lat1_nxt  = 8'h00;
            stat0_nxt = 8'h00;
            stat1_nxt = 8'h00;
          end
          ptr_nxt = advance(ptr_r);
        end
      end
      default: begin
      end
    endcase

    // end of write message: fold unmasked input changes into status
    if (do_irq) begin
      c0        = (in0_nxt ^ prev0_r) & ~mask0_nxt;
      c1        = (in1_nxt ^ prev1_r) & ~mask1_nxt;
      lat0_nxt  = (|latch0_nxt) ? (lat0_r | c0) : c0;
      lat1_nxt  = (|latch1_nxt) ? (lat1_r | c1) : c1;
      stat0_nxt = lat0_nxt;
      stat1_nxt = lat1_nxt;
    end

    out_item_nxt.read_data  = rdata;
    out_item_nxt.read_valid = rvalid;
    out_item_nxt.int_n      = ~|(lat0_nxt | lat1_nxt);
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      item_r <= in_item;
    end
    if (ctl.exec) begin
      out_item_r <= out_item_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r    <= 8'h00;
      in0_r    <= 8'h00;
      in1_r    <= 8'h00;
      latch0_r <= 8'h00;
      latch1_r <= 8'h00;
      mask0_r  <= BYTE_ONES;
      mask1_r  <= BYTE_ONES;
      stat0_r  <= 8'h00;
      stat1_r  <= 8'h00;
      prev0_r  <= 8'h00;
      prev1_r  <= 8'h00;
      lat0_r   <= 8'h00;
      lat1_r   <= 8'h00;
    end else if (ctl.exec) begin
      ptr_r    <= ptr_nxt;
      in0_r    <= in0_nxt;
      in1_r    <= in1_nxt;
      latch0_r <= latch0_nxt;
      latch1_r <= latch1_nxt;
      mask0_r  <= mask0_nxt;
      mask1_r  <= mask1_nxt;
      stat0_r  <= stat0_nxt;
      stat1_r  <= stat1_nxt;
      prev0_r  <= prev0_nxt;
      prev1_r  <= prev1_nxt;
      lat0_r   <= lat0_nxt;
      lat1_r   <= lat1_nxt;
    end
  end

  assign out_item = out_item_r;

endmodule

`default_nettype wire

// ===== rtl/core/io_expander_register_file_core.sv =====
`default_nettype none

// Channel   Direction  Handshake           Payload
// in_       input      in_valid/in_ready   in_item  (cmd, data, last)
// out_      output     out_valid/out_ready out_item (read_data, read_valid, int_n)
//
// Each transaction passes an accept state, then an execute state, paced by the
// registered read port of the register memory.
// One transaction in flight; execute waits while the result register is full.
// rst_n is synchronous; per-entry valid bits give the reset defaults, so no
// clearing pass is needed and a transaction may be accepted right after reset.
// out_ready low holds the result and, once the next transaction is taken, in_ready.

module io_expander_register_file_core #(
  parameter int unsigned REG_COUNT = ioxrf_pkg::REG_COUNT_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire ioxrf_pkg::in_item_t  in_item,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output ioxrf_pkg::out_item_t      out_item
);
  import ioxrf_pkg::*;

  ctl_t ctl;

  ioxrf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .ctl       (ctl)
  );

  ioxrf_dpath #(
    .REG_COUNT (REG_COUNT)
  ) u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .in_item  (in_item),
    .out_item (out_item)
  );

endmodule

`default_nettype wire
